// File: rtl/lcb_pkg.sv
// ============================================================================
// lcb_pkg: shared constants, types and tables of the lit region crop box
// Holds the sRGB linearisation table, the lit threshold table and the types
// that travel between the pipeline stages.
// ============================================================================
package lcb_pkg;

    // Frame geometry and field widths.
    localparam int unsigned MAX_COLUMNS      = 1024;
    localparam int unsigned MAX_ROWS         = 1024;
    localparam int unsigned POS_W            = 10;
    localparam int unsigned DIM_W            = 11;
    localparam int unsigned LEVEL_W          = 7;
    localparam int unsigned CODE_W           = 16;
    localparam int unsigned LIN_W            = 16;
    localparam int unsigned CFG_INDEX_W      = 2;

    // Linearisation table.
    localparam int unsigned GAMMA_TABLE_BITS = 12;
    localparam int unsigned TABLE_SIZE       = 1 << GAMMA_TABLE_BITS;
    localparam int unsigned GAMMA_LIN_DIV    = 2 * 1292 * TABLE_SIZE;
    localparam int unsigned GAMMA_LIN_HALF   = 1292 * TABLE_SIZE;
    localparam int unsigned GAMMA_POW_DIV    = 1055 * TABLE_SIZE;

    // Luminance weights; Y = round((WR*R + WG*G + WB*B) / Y_SCALE).
    localparam int unsigned WEIGHT_R         = 2126;
    localparam int unsigned WEIGHT_G         = 7152;
    localparam int unsigned WEIGHT_B         = 722;
    localparam int unsigned Y_SCALE          = 10000;
    localparam int unsigned Y_ROUND          = 5000;
    localparam int unsigned SUM_W            = 30;
    localparam int unsigned THR_W            = SUM_W + 1;
    localparam int unsigned Y_SEARCH_MAX     = 65536;

    // L* in Q.8, linear segment below the CIE knee.
    localparam int unsigned LSTAR_LIN_DIV    = 2 * 27 * 65536;
    localparam int unsigned LSTAR_LIN_HALF   = 27 * 65536;
    localparam int unsigned LEVELS           = 1 << LEVEL_W;

    // Weighted sum that no pixel can reach: the level is never met.
    localparam logic [THR_W-1:0] THR_NEVER   = THR_W'(1) << SUM_W;

    // Register reset values.
    localparam logic [DIM_W-1:0]   FRAME_COLUMNS_RESET = DIM_W'(64);
    localparam logic [DIM_W-1:0]   FRAME_ROWS_RESET    = DIM_W'(64);
    localparam logic [LEVEL_W-1:0] LIT_LEVEL_RESET     = LEVEL_W'(10);

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_COLUMNS = 2'd0,
        REG_FRAME_ROWS    = 2'd1,
        REG_LIT_LEVEL     = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [POS_W-1:0] col_last;
        logic [POS_W-1:0] row_last;
    } frame_limits_t;

    typedef struct packed {
        logic             valid;
        logic             last_frame;
        logic [SUM_W-1:0] sum;
    } luma_item_t;

    typedef struct packed {
        logic             valid;
        logic             last_frame;
        logic [POS_W-1:0] top;
        logic [POS_W-1:0] bottom;
        logic [POS_W-1:0] left;
        logic [POS_W-1:0] right;
    } frame_box_t;

    typedef logic [TABLE_SIZE-1:0][LIN_W-1:0] lin_table_t;
    typedef logic [LEVELS-1:0][THR_W-1:0]     thr_table_t;

    // Linear light of one table index, Q0.16.
    function automatic logic [LIN_W-1:0] gamma_entry(input int unsigned i);
        longint unsigned ii;
        longint unsigned t16;
        longint unsigned u;
        longint unsigned target;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned entry;
        ii = i;
        if (ii * 100000 <= 4045 * TABLE_SIZE) begin
            entry = (ii * 6553600 * 2 + GAMMA_LIN_HALF) / GAMMA_LIN_DIV;
        end
        else begin
            t16    = ((ii * 1000 + 55 * TABLE_SIZE) << 16) / GAMMA_POW_DIV;
            u      = t16 * t16;
            target = u << 28;
            lo     = 0;
            hi     = 4095;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                if (mid * mid * mid * mid * mid <= target) lo = mid;
                else hi = mid - 1;
            end
            entry = (u * lo) >> 28;
        end
        return LIN_W'(entry);
    endfunction

    // L* in Q.8 of a luminance in Q0.16.
    function automatic longint unsigned lightness_q8(input longint unsigned y);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned l;
        if (y * 24389 <= 216 * 65536) begin
            return (y * 24389 * 512 + LSTAR_LIN_HALF) / LSTAR_LIN_DIV;
        end
        lo = 0;
        hi = 65535;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid * mid <= (y << 32)) lo = mid;
            else hi = mid - 1;
        end
        l = (116 * lo) >> 8;
        return (l >= 4096) ? l - 4096 : 0;
    endfunction

    // Smallest weighted sum whose rounded luminance reaches the given level.
    // L* rises with Y, so the test on L* becomes one compare on the sum.
    function automatic logic [THR_W-1:0] lit_sum_threshold(input int unsigned level);
        longint unsigned target;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        target = longint'(level) * 256;
        if (lightness_q8(Y_SEARCH_MAX) < target) begin
            return THR_NEVER;
        end
        lo = 0;
        hi = Y_SEARCH_MAX;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (lightness_q8(mid) >= target) hi = mid;
            else lo = mid + 1;
        end
        if (lo == 0) begin
            return '0;
        end
        return THR_W'(lo * Y_SCALE - Y_ROUND);
    endfunction

    function automatic lin_table_t build_lin_table();
        lin_table_t t;
        for (int unsigned i = 0; i < TABLE_SIZE; i++) begin
            t[i] = gamma_entry(i);
        end
        return t;
    endfunction

    function automatic thr_table_t build_thr_table();
        thr_table_t t;
        for (int unsigned i = 0; i < LEVELS; i++) begin
            t[i] = lit_sum_threshold(i);
        end
        return t;
    endfunction

    localparam lin_table_t LIN_TABLE     = build_lin_table();
    localparam thr_table_t LIT_SUM_TABLE = build_thr_table();

endpackage

// File: rtl/lcb_luma.sv
// ============================================================================
// lcb_luma: linearisation and luminance stages
// Reads the three channels through the sRGB ROM, then forms the weighted
// luminance sum, one register stage each.
// ============================================================================
module lcb_luma (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [lcb_pkg::CODE_W-1:0]   red,
    input  logic [lcb_pkg::CODE_W-1:0]   green,
    input  logic [lcb_pkg::CODE_W-1:0]   blue,
    input  logic                         last_frame,
    output lcb_pkg::luma_item_t          item
);

    localparam int unsigned IDX_HI = lcb_pkg::CODE_W - 1;

    logic                        rom_valid_reg;
    logic                        rom_last_reg;
    logic [lcb_pkg::LIN_W-1:0]   lin_r_reg;
    logic [lcb_pkg::LIN_W-1:0]   lin_g_reg;
    logic [lcb_pkg::LIN_W-1:0]   lin_b_reg;
    logic                        sum_valid_reg;
    logic                        sum_last_reg;
    logic [lcb_pkg::SUM_W-1:0]   sum_reg;
    logic [lcb_pkg::SUM_W-1:0]   sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rom_valid_reg <= in_valid;
            sum_valid_reg <= rom_valid_reg;
        end
    end

    // ROM read with registered data; the index is the top bits of each code.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_r_reg    <= lcb_pkg::LIN_TABLE[red[IDX_HI -: lcb_pkg::GAMMA_TABLE_BITS]];
            lin_g_reg    <= lcb_pkg::LIN_TABLE[green[IDX_HI -: lcb_pkg::GAMMA_TABLE_BITS]];
            lin_b_reg    <= lcb_pkg::LIN_TABLE[blue[IDX_HI -: lcb_pkg::GAMMA_TABLE_BITS]];
            rom_last_reg <= last_frame;
            sum_reg      <= sum_next;
            sum_last_reg <= rom_last_reg;
        end
    end

    always_comb
    begin
        sum_next = lcb_pkg::SUM_W'(lcb_pkg::WEIGHT_R * lin_r_reg)
                 + lcb_pkg::SUM_W'(lcb_pkg::WEIGHT_G * lin_g_reg)
                 + lcb_pkg::SUM_W'(lcb_pkg::WEIGHT_B * lin_b_reg);
    end

    assign item.valid      = sum_valid_reg;
    assign item.last_frame = sum_last_reg;
    assign item.sum        = sum_reg;

endmodule

// File: rtl/lcb_frame_track.sv
// ============================================================================
// lcb_frame_track: lit decision and per-frame extent tracking
// Compares the luminance sum with the level threshold, walks the raster
// position and hands out one box item as each frame completes.
// ============================================================================
module lcb_frame_track (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  lcb_pkg::luma_item_t           item,
    input  logic [lcb_pkg::THR_W-1:0]     thr,
    input  lcb_pkg::frame_limits_t        limits,
    output lcb_pkg::frame_box_t           box
);

    localparam int unsigned W = lcb_pkg::POS_W;

    logic         lit_valid_reg;
    logic         lit_reg;
    logic         lit_last_reg;

    logic [W-1:0] col_pos_reg;
    logic [W-1:0] col_pos_next;
    logic [W-1:0] row_pos_reg;
    logic [W-1:0] row_pos_next;
    logic         any_reg;
    logic         any_next;
    logic [W-1:0] first_row_reg;
    logic [W-1:0] first_row_next;
    logic [W-1:0] last_row_reg;
    logic [W-1:0] last_row_next;
    logic [W-1:0] first_col_reg;
    logic [W-1:0] first_col_next;
    logic [W-1:0] last_col_reg;
    logic [W-1:0] last_col_next;

    logic         box_valid_reg;
    logic         box_valid_next;
    logic         box_last_reg;
    logic [W-1:0] box_top_reg;
    logic [W-1:0] box_bottom_reg;
    logic [W-1:0] box_left_reg;
    logic [W-1:0] box_right_reg;
    logic [W-1:0] box_top_next;
    logic [W-1:0] box_bottom_next;
    logic [W-1:0] box_left_next;
    logic [W-1:0] box_right_next;

    // Frame extents with the current pixel folded in.
    logic         any_u;
    logic [W-1:0] first_row_u;
    logic [W-1:0] last_row_u;
    logic [W-1:0] first_col_u;
    logic [W-1:0] last_col_u;
    logic         row_end;
    logic         frame_end;

    always_comb
    begin
        any_u       = any_reg | lit_reg;
        first_row_u = (lit_reg && !any_reg) ? row_pos_reg : first_row_reg;
        last_row_u  = lit_reg ? row_pos_reg : last_row_reg;
        first_col_u = (lit_reg && (!any_reg || col_pos_reg < first_col_reg))
                    ? col_pos_reg : first_col_reg;
        last_col_u  = (lit_reg && (!any_reg || col_pos_reg > last_col_reg))
                    ? col_pos_reg : last_col_reg;

        row_end   = col_pos_reg >= limits.col_last;
        frame_end = row_end && (row_pos_reg >= limits.row_last);

        box_top_next    = any_u ? first_row_u : '0;
        box_left_next   = any_u ? first_col_u : '0;
        box_bottom_next = (any_u && last_row_u < limits.row_last)
                        ? last_row_u + W'(1) : limits.row_last;
        box_right_next  = (any_u && last_col_u < limits.col_last)
                        ? last_col_u + W'(1) : limits.col_last;

        col_pos_next   = col_pos_reg;
        row_pos_next   = row_pos_reg;
        any_next       = any_reg;
        first_row_next = first_row_reg;
        last_row_next  = last_row_reg;
        first_col_next = first_col_reg;
        last_col_next  = last_col_reg;
        box_valid_next = 1'b0;

        if (lit_valid_reg)
        begin
            if (frame_end)
            begin
                col_pos_next   = '0;
                row_pos_next   = '0;
                any_next       = 1'b0;
                first_row_next = '0;
                last_row_next  = '0;
                first_col_next = '0;
                last_col_next  = '0;
                box_valid_next = 1'b1;
            end
            else
            begin
                col_pos_next   = row_end ? '0 : col_pos_reg + W'(1);
                row_pos_next   = row_end ? row_pos_reg + W'(1) : row_pos_reg;
                any_next       = any_u;
                first_row_next = first_row_u;
                last_row_next  = last_row_u;
                first_col_next = first_col_u;
                last_col_next  = last_col_u;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_valid_reg <= 1'b0;
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            any_reg       <= 1'b0;
            first_row_reg <= '0;
            last_row_reg  <= '0;
            first_col_reg <= '0;
            last_col_reg  <= '0;
            box_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            lit_valid_reg <= item.valid;
            col_pos_reg   <= col_pos_next;
            row_pos_reg   <= row_pos_next;
            any_reg       <= any_next;
            first_row_reg <= first_row_next;
            last_row_reg  <= last_row_next;
            first_col_reg <= first_col_next;
            last_col_reg  <= last_col_next;
            box_valid_reg <= box_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lit_reg        <= {1'b0, item.sum} >= thr;
            lit_last_reg   <= item.last_frame;
            box_last_reg   <= lit_last_reg;
            box_top_reg    <= box_top_next;
            box_bottom_reg <= box_bottom_next;
            box_left_reg   <= box_left_next;
            box_right_reg  <= box_right_next;
        end
    end

    assign box.valid      = box_valid_reg;
    assign box.last_frame = box_last_reg;
    assign box.top        = box_top_reg;
    assign box.bottom     = box_bottom_reg;
    assign box.left       = box_left_reg;
    assign box.right      = box_right_reg;

endmodule

// File: rtl/lcb_box_merge.sv
// ============================================================================
// lcb_box_merge: sequence box accumulation and result register
// Keeps the union of the frame boxes and loads the result register when the
// final frame of a sequence completes.
// ============================================================================
module lcb_box_merge (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  lcb_pkg::frame_box_t          box,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [lcb_pkg::POS_W-1:0]    box_x,
    output logic [lcb_pkg::POS_W-1:0]    box_y,
    output logic [lcb_pkg::POS_W-1:0]    box_width,
    output logic [lcb_pkg::POS_W-1:0]    box_height
);

    localparam int unsigned W = lcb_pkg::POS_W;

    logic [W-1:0] seq_top_reg;
    logic [W-1:0] seq_bottom_reg;
    logic [W-1:0] seq_left_reg;
    logic [W-1:0] seq_right_reg;
    logic [W-1:0] top_n;
    logic [W-1:0] bottom_n;
    logic [W-1:0] left_n;
    logic [W-1:0] right_n;
    logic [W-1:0] width_n;
    logic [W-1:0] height_n;
    logic         take;
    logic         emit;

    logic         out_valid_reg;
    logic         out_valid_next;
    logic [W-1:0] out_x_reg;
    logic [W-1:0] out_y_reg;
    logic [W-1:0] out_w_reg;
    logic [W-1:0] out_h_reg;

    always_comb
    begin
        take     = en && box.valid;
        emit     = take && box.last_frame;
        top_n    = (box.top < seq_top_reg) ? box.top : seq_top_reg;
        left_n   = (box.left < seq_left_reg) ? box.left : seq_left_reg;
        bottom_n = (box.bottom > seq_bottom_reg) ? box.bottom : seq_bottom_reg;
        right_n  = (box.right > seq_right_reg) ? box.right : seq_right_reg;
        width_n  = (right_n > left_n) ? right_n - left_n : '0;
        height_n = (bottom_n > top_n) ? bottom_n - top_n : '0;

        if (emit) out_valid_next = 1'b1;
        else if (out_ready) out_valid_next = 1'b0;
        else out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_top_reg    <= '1;
            seq_left_reg   <= '1;
            seq_bottom_reg <= '0;
            seq_right_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                if (emit)
                begin
                    seq_top_reg    <= '1;
                    seq_left_reg   <= '1;
                    seq_bottom_reg <= '0;
                    seq_right_reg  <= '0;
                end
                else
                begin
                    seq_top_reg    <= top_n;
                    seq_left_reg   <= left_n;
                    seq_bottom_reg <= bottom_n;
                    seq_right_reg  <= right_n;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_x_reg <= left_n;
            out_y_reg <= top_n;
            out_w_reg <= width_n;
            out_h_reg <= height_n;
        end
    end

    assign out_valid  = out_valid_reg;
    assign box_x      = out_x_reg;
    assign box_y      = out_y_reg;
    assign box_width  = out_w_reg;
    assign box_height = out_h_reg;

endmodule

// File: rtl/lit_region_crop_box_core.sv
// ============================================================================
// lit_region_crop_box_core: common crop box of the lit region of a sequence
// Path: the item that completes the final frame is loaded into the ROM read
// register on the edge that accepts it, then passes the weighted sum, lit
// compare, frame tracker and result register, and waits only while the
// output is stalled. Throughput: one pixel item per cycle, set by the
// single-pass pipeline, except while a finished result waits on the output.
// Reset: rst_n clears positions, frame and sequence extents, and the result
// valid, and loads the register defaults (64 columns, 64 rows, level 10).
// ============================================================================
module lit_region_crop_box_core (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,

    // Pixel items in.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // red [15:0], green [31:16], blue [47:32]
    input  logic        s_tuser,   // last_frame [0]

    // Crop box result items out.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // box_x [9:0], box_y [19:10],
                                   // box_width [29:20], box_height [39:30]
);

    localparam int unsigned W  = lcb_pkg::POS_W;
    localparam int unsigned CW = lcb_pkg::CODE_W;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always accepted; they are only
    // meant to arrive while no item is in flight, so no interlock is kept
    // against the pipeline.
    // ------------------------------------------------------------------
    logic [lcb_pkg::DIM_W-1:0]   frame_columns_reg;
    logic [lcb_pkg::DIM_W-1:0]   frame_rows_reg;
    logic [lcb_pkg::LEVEL_W-1:0] lit_level_reg;
    logic [lcb_pkg::THR_W-1:0]   thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_columns_reg <= lcb_pkg::FRAME_COLUMNS_RESET;
            frame_rows_reg    <= lcb_pkg::FRAME_ROWS_RESET;
            lit_level_reg     <= lcb_pkg::LIT_LEVEL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lcb_pkg::REG_FRAME_COLUMNS: frame_columns_reg <= cfg_data;
                lcb_pkg::REG_FRAME_ROWS:    frame_rows_reg    <= cfg_data;
                lcb_pkg::REG_LIT_LEVEL:     lit_level_reg     <= cfg_data[lcb_pkg::LEVEL_W-1:0];
                default:                    ;
            endcase
        end
    end

    // The level is turned into a threshold on the weighted luminance sum
    // through a small constant table, so the per-pixel path needs neither
    // a divide nor a cube root. It is registered off the pixel path.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= lcb_pkg::LIT_SUM_TABLE[lcb_pkg::LIT_LEVEL_RESET];
        end
        else
        begin
            thr_reg <= lcb_pkg::LIT_SUM_TABLE[lit_level_reg];
        end
    end

    // Frame size as last index: zero acts as one, and anything past the
    // maximum acts as the maximum.
    lcb_pkg::frame_limits_t limits;

    always_comb
    begin
        if (frame_columns_reg == '0)
            limits.col_last = '0;
        else if (frame_columns_reg > lcb_pkg::DIM_W'(lcb_pkg::MAX_COLUMNS))
            limits.col_last = W'(lcb_pkg::MAX_COLUMNS - 1);
        else
            limits.col_last = W'(frame_columns_reg - lcb_pkg::DIM_W'(1));

        if (frame_rows_reg == '0)
            limits.row_last = '0;
        else if (frame_rows_reg > lcb_pkg::DIM_W'(lcb_pkg::MAX_ROWS))
            limits.row_last = W'(lcb_pkg::MAX_ROWS - 1);
        else
            limits.row_last = W'(frame_rows_reg - lcb_pkg::DIM_W'(1));
    end

    // ------------------------------------------------------------------
    // Pipeline advance. The whole pipeline moves together; it only holds
    // when a new result is about to be formed while the previous one is
    // still waiting in the result register. Pixels keep flowing while a
    // result waits, since only the final pixel of a sequence makes one.
    // ------------------------------------------------------------------
    lcb_pkg::luma_item_t luma_item;
    lcb_pkg::frame_box_t frame_box;
    logic                en;

    assign en       = !(frame_box.valid && frame_box.last_frame && m_tvalid && !m_tready);
    assign s_tready = en;

    lcb_luma u_luma (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid),
        .red        (s_tdata[CW-1:0]),
        .green      (s_tdata[2*CW-1:CW]),
        .blue       (s_tdata[3*CW-1:2*CW]),
        .last_frame (s_tuser),
        .item       (luma_item)
    );

    lcb_frame_track u_frame_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .item   (luma_item),
        .thr    (thr_reg),
        .limits (limits),
        .box    (frame_box)
    );

    logic [W-1:0] box_x;
    logic [W-1:0] box_y;
    logic [W-1:0] box_width;
    logic [W-1:0] box_height;

    lcb_box_merge u_box_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .box        (frame_box),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .box_x      (box_x),
        .box_y      (box_y),
        .box_width  (box_width),
        .box_height (box_height)
    );

    assign m_tdata = {box_height, box_width, box_y, box_x};

endmodule

// File: rtl/lcb_checker.sv
// ============================================================================
// lcb_checker: port-level assertions of the lit region crop box
// Watches the stream ports of the top level and is bound to it below.
// ============================================================================
module lcb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata
);

    // A waiting result item holds still until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed or vanished while stalled");

    // Input is only held off while a result waits and is not being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting result");

    // The box never reaches past the last column.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[9:0]} + {1'b0, m_tdata[29:20]}) <= 11'd1023)
        else $error("box extends past the last column");

    // The box never reaches past the last row.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[19:10]} + {1'b0, m_tdata[39:30]}) <= 11'd1023)
        else $error("box extends past the last row");

endmodule

bind lit_region_crop_box_core lcb_checker u_lcb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: dv/lit_region_crop_box_core_tb.sv
// ============================================================================
// lit_region_crop_box_core_tb: self-checking bench of the lit region crop box
// Streams RGB pixel items through the block and predicts every crop box from
// its own fixed-point model of the sRGB curve, luminance and CIE L*. It covers
// directed corner cases, then random frame sequences under several register
// settings and three idling schemes on both stream sides.
// ============================================================================
module lit_region_crop_box_core_tb;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [lcb_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    // The table index is the top GAMMA_TABLE_BITS bits of a 16-bit code.
    localparam int unsigned LUT_SHIFT = lcb_pkg::CODE_W - lcb_pkg::GAMMA_TABLE_BITS;

    // Waiting this long once the last expected box has arrived covers any item
    // still in flight in the block.
    localparam int unsigned SETTLE_CYCLES = 10;

    localparam int unsigned MAX_REPORTS = 10;

    // Least number of random items sent in each of the three idling stretches.
    localparam int unsigned STRETCH_ITEMS = 250;

    // Result fields, box_x in the lowest bits as on m_tdata.
    typedef struct packed {
        logic [lcb_pkg::POS_W-1:0] box_height;
        logic [lcb_pkg::POS_W-1:0] box_width;
        logic [lcb_pkg::POS_W-1:0] box_y;
        logic [lcb_pkg::POS_W-1:0] box_x;
    } crop_box_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the registers and the frame and sequence extents,
    // predicts the crop box of each completed sequence and checks the boxes
    // that the block delivers, oldest first.
    // ------------------------------------------------------------------------
    class crop_box_scoreboard;
        int unsigned                 lin_q16 [lcb_pkg::TABLE_SIZE];
        logic [lcb_pkg::DIM_W-1:0]   columns_reg;
        logic [lcb_pkg::DIM_W-1:0]   rows_reg;
        logic [lcb_pkg::LEVEL_W-1:0] level_reg;
        int unsigned                 col_pos;
        int unsigned                 row_pos;
        bit                          frame_lit;
        int unsigned                 first_row;
        int unsigned                 last_row;
        int unsigned                 first_col;
        int unsigned                 last_col;
        int unsigned                 seq_top;
        int unsigned                 seq_bottom;
        int unsigned                 seq_left;
        int unsigned                 seq_right;
        crop_box_t                   boxes_due [$];
        int unsigned                 boxes_expected;
        int unsigned                 failures;

        function new();
            for (int unsigned i = 0; i < lcb_pkg::TABLE_SIZE; i++) begin
                lin_q16[i] = srgb_linear(i);
            end
            columns_reg    = lcb_pkg::FRAME_COLUMNS_RESET;
            rows_reg       = lcb_pkg::FRAME_ROWS_RESET;
            level_reg      = lcb_pkg::LIT_LEVEL_RESET;
            boxes_expected = 0;
            failures       = 0;
            clear_frame();
            clear_sequence();
        endfunction

        // Linear light in Q0.16 of one table index: straight segment near
        // black, 2.4 power law above it via a fifth root of the square.
        function int unsigned srgb_linear(int unsigned idx);
            longint unsigned i;
            longint unsigned n;
            longint unsigned t16;
            longint unsigned u;
            longint unsigned goal;
            longint unsigned lo;
            longint unsigned hi;
            longint unsigned mid;
            i = idx;
            n = lcb_pkg::TABLE_SIZE;
            if (i * 100000 <= 4045 * n) begin
                return int'((i * 6553600 * 2 + 1292 * n) / (2 * 1292 * n));
            end
            t16  = ((i * 1000 + 55 * n) << 16) / (1055 * n);
            u    = t16 * t16;
            goal = u << 28;
            lo   = 0;
            hi   = 4095;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                if (mid * mid * mid * mid * mid <= goal) lo = mid;
                else hi = mid - 1;
            end
            return int'((u * lo) >> 28);
        endfunction

        // CIE L* in Q.8 of a luminance in Q0.16.
        function longint unsigned lightness(longint unsigned y);
            longint unsigned lo;
            longint unsigned hi;
            longint unsigned mid;
            longint unsigned l;
            if (y * 24389 <= 216 * 65536) begin
                return (y * 24389 * 512 + 27 * 65536) / (2 * 27 * 65536);
            end
            lo = 0;
            hi = 65535;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                if (mid * mid * mid <= (y << 32)) lo = mid;
                else hi = mid - 1;
            end
            l = (116 * lo) >> 8;
            return (l >= 4096) ? l - 4096 : 0;
        endfunction

        function int unsigned clamp_dim(logic [lcb_pkg::DIM_W-1:0] v, int unsigned max);
            if (v == 0) return 1;
            return (v > max) ? max : v;
        endfunction

        function void clear_frame();
            col_pos   = 0;
            row_pos   = 0;
            frame_lit = 0;
            first_row = 0;
            last_row  = 0;
            first_col = 0;
            last_col  = 0;
        endfunction

        function void clear_sequence();
            seq_top    = 1023;
            seq_left   = 1023;
            seq_bottom = 0;
            seq_right  = 0;
        endfunction

        function void write_reg(logic [lcb_pkg::CFG_INDEX_W-1:0] idx,
                                logic [lcb_pkg::DIM_W-1:0] data);
            case (idx)
                lcb_pkg::REG_FRAME_COLUMNS: columns_reg = data;
                lcb_pkg::REG_FRAME_ROWS:    rows_reg    = data;
                lcb_pkg::REG_LIT_LEVEL:     level_reg   = data[lcb_pkg::LEVEL_W-1:0];
                default:                    ;
            endcase
        endfunction

        // True when the next pixel closes the current frame.
        function bit frame_ends_next();
            return (col_pos + 1 >= clamp_dim(columns_reg, lcb_pkg::MAX_COLUMNS)) &&
                   (row_pos + 1 >= clamp_dim(rows_reg, lcb_pkg::MAX_ROWS));
        endfunction

        function int unsigned pending();
            return boxes_due.size();
        endfunction

        function void note_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                 logic last_frame);
            int unsigned     cols;
            int unsigned     rows;
            int unsigned     top;
            int unsigned     bottom;
            int unsigned     left;
            int unsigned     right;
            longint unsigned y;
            bit              lit;
            crop_box_t       box;
            cols = clamp_dim(columns_reg, lcb_pkg::MAX_COLUMNS);
            rows = clamp_dim(rows_reg, lcb_pkg::MAX_ROWS);
            y = (longint'(2126) * lin_q16[r >> LUT_SHIFT] +
                 longint'(7152) * lin_q16[g >> LUT_SHIFT] +
                 longint'(722)  * lin_q16[b >> LUT_SHIFT] + 5000) / 10000;
            lit = lightness(y) >= longint'(level_reg) * 256;

            if (lit) begin
                if (!frame_lit) begin
                    first_row = row_pos;
                    first_col = col_pos;
                    last_col  = col_pos;
                    frame_lit = 1;
                end
                if (col_pos < first_col) first_col = col_pos;
                if (col_pos > last_col)  last_col  = col_pos;
                last_row = row_pos;
            end

            // A lowered dimension ends the row or frame at once.
            if (col_pos + 1 < cols) begin
                col_pos++;
                return;
            end
            col_pos = 0;
            if (row_pos + 1 < rows) begin
                row_pos++;
                return;
            end

            top    = 0;
            bottom = rows - 1;
            left   = 0;
            right  = cols - 1;
            if (frame_lit) begin
                top  = first_row;
                left = first_col;
                if (last_row + 1 < rows) bottom = last_row + 1;
                if (last_col + 1 < cols) right  = last_col + 1;
            end
            if (top < seq_top)       seq_top    = top;
            if (left < seq_left)     seq_left   = left;
            if (bottom > seq_bottom) seq_bottom = bottom;
            if (right > seq_right)   seq_right  = right;
            clear_frame();

            // The flag counts only on the pixel that closes a frame.
            if (last_frame) begin
                box.box_x      = lcb_pkg::POS_W'(seq_left);
                box.box_y      = lcb_pkg::POS_W'(seq_top);
                box.box_width  = lcb_pkg::POS_W'((seq_right > seq_left) ?
                                                 seq_right - seq_left : 0);
                box.box_height = lcb_pkg::POS_W'((seq_bottom > seq_top) ?
                                                 seq_bottom - seq_top : 0);
                boxes_due.push_back(box);
                boxes_expected++;
                clear_sequence();
            end
        endfunction

        function void check_box(logic [39:0] data);
            crop_box_t got;
            crop_box_t want;
            got = data;
            if (boxes_due.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected crop box x=%0d y=%0d w=%0d h=%0d",
                             got.box_x, got.box_y, got.box_width, got.box_height);
                return;
            end
            want = boxes_due.pop_front();
            if (got.box_x !== want.box_x || got.box_y !== want.box_y ||
                got.box_width !== want.box_width ||
                got.box_height !== want.box_height) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display({"crop box differs: expected x=%0d y=%0d w=%0d h=%0d, ",
                              "got x=%0d y=%0d w=%0d h=%0d"},
                             want.box_x, want.box_y, want.box_width, want.box_height,
                             got.box_x, got.box_y, got.box_width, got.box_height);
            end
        endfunction

        function void close_out();
            if (boxes_due.size() != 0) begin
                failures += boxes_due.size();
                $display("%0d crop boxes never arrived", boxes_due.size());
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block signals. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [lcb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [lcb_pkg::DIM_W-1:0]       cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [47:0]                     s_tdata   = '0;   // red [15:0], green [31:16],
                                                       // blue [47:32]
    logic                            s_tuser   = 1'b0; // last_frame [0]
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [39:0]                     m_tdata;          // box_x [9:0], box_y [19:10],
                                                       // box_width [29:20],
                                                       // box_height [39:30]

    crop_box_scoreboard sb;

    // Percentages of cycles in which each side holds back.
    int unsigned sender_idle_pct   = 20;
    int unsigned receiver_idle_pct = 48;

    always #4 clk = ~clk;

    lit_region_crop_box_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Result side: signals are read just after the edge, so they still hold
    // the values that the edge itself saw. Ready is redrawn every cycle.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) sb.check_box(m_tdata);
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Driving tasks.
    // ------------------------------------------------------------------------

    // Offers one pixel item, after a random number of idle cycles, and notes
    // it with the scoreboard once it has been taken. Valid is left high so
    // that back-to-back items keep a single assignment per edge.
    task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b, input logic last_frame);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        s_tuser  <= last_frame;
        do @(posedge clk); while (!s_tready);
        sb.note_pixel(r, g, b, last_frame);
    endtask

    // Stops the pixel stream and waits until every expected box has come out
    // and the pipeline has emptied, so that registers may be written.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lcb_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lcb_pkg::DIM_W-1:0] data, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        if (last) cfg_valid <= 1'b0;
    endtask

    // The level write may carry junk in the bits above the 7-bit field.
    task automatic set_config(input logic [lcb_pkg::DIM_W-1:0] columns,
                              input logic [lcb_pkg::DIM_W-1:0] rows,
                              input logic [lcb_pkg::DIM_W-1:0] level,
                              input bit spare_write);
        drain_pipeline();
        write_reg(lcb_pkg::REG_FRAME_COLUMNS, columns, 1'b0);
        write_reg(lcb_pkg::REG_FRAME_ROWS, rows, 1'b0);
        if (spare_write)
            write_reg(REG_SPARE, lcb_pkg::DIM_W'($urandom_range(2047)), 1'b0);
        write_reg(lcb_pkg::REG_LIT_LEVEL, level, 1'b1);
    endtask

    function automatic logic [15:0] channel_value(bit bright);
        if (bright) begin
            if ($urandom_range(99) < 15) return 16'hFFFF;
            return 16'($urandom_range(65535));
        end
        if ($urandom_range(99) < 15) return 16'h0000;
        return 16'($urandom_range(16'h0A00));
    endfunction

    // Sends pixels until the given number of frames has closed. The flag is
    // set on the closing pixel of the final frame only; other pixels carry it
    // mostly consistent with their frame and sometimes at random. A broken
    // run stops partway, leaving a frame open for the next setting.
    task automatic run_frames(input int nframes, input int bright_pct, input bit broken,
                              input bit lit_tail, output int sent);
        int   done;
        int   cut;
        bit   ends;
        bit   bright;
        logic flag;
        done = 0;
        sent = 0;
        cut  = broken ? $urandom_range(1, 30) : -1;
        while (done < nframes && sent != cut) begin
            ends   = sb.frame_ends_next();
            bright = ($urandom_range(99) < bright_pct) || (ends && lit_tail);
            if (ends)
                flag = (done == nframes - 1);
            else if ($urandom_range(99) < 20)
                flag = 1'($urandom_range(1));
            else
                flag = (done == nframes - 1);
            send_pixel(channel_value(bright), channel_value(bright),
                       channel_value(bright), flag);
            sent++;
            if (ends) done++;
        end
    endtask

    // One random phase: a fresh setting, then one to three frames.
    task automatic random_phase(output int sent);
        logic [lcb_pkg::DIM_W-1:0] columns;
        logic [lcb_pkg::DIM_W-1:0] rows;
        logic [lcb_pkg::DIM_W-1:0] level;
        int                        bright_pct;
        case ($urandom_range(9))
            0:       columns = '0;
            1:       columns = lcb_pkg::DIM_W'($urandom_range(7, 16));
            default: columns = lcb_pkg::DIM_W'($urandom_range(1, 6));
        endcase
        case ($urandom_range(9))
            0:       rows = '0;
            1:       rows = lcb_pkg::DIM_W'($urandom_range(6, 10));
            default: rows = lcb_pkg::DIM_W'($urandom_range(1, 5));
        endcase
        case ($urandom_range(9))
            0:       level = lcb_pkg::DIM_W'(0);
            1:       level = lcb_pkg::DIM_W'($urandom_range(100, 127));
            2:       level = lcb_pkg::DIM_W'(1);
            3:       level = lcb_pkg::DIM_W'(100);
            default: level = lcb_pkg::DIM_W'($urandom_range(1, 40));
        endcase
        if ($urandom_range(3) == 0)
            level[lcb_pkg::DIM_W-1:lcb_pkg::LEVEL_W] = 4'($urandom_range(15));
        case ($urandom_range(4))
            0:       bright_pct = 0;
            1:       bright_pct = 10;
            2:       bright_pct = 30;
            3:       bright_pct = 60;
            default: bright_pct = 100;
        endcase
        set_config(columns, rows, level, $urandom_range(9) == 0);
        run_frames($urandom_range(1, 3), bright_pct, $urandom_range(99) < 15, 1'b0, sent);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        int sent;
        int random_items;
        int seg_start;
        sb = new();
        random_items = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A few pixels at the reset geometry and level, then a one by one
        // setting closes the open frame and ends the sequence.
        run_frames(1, 50, 1'b1, 1'b0, sent);
        set_config(lcb_pkg::DIM_W'(1), lcb_pkg::DIM_W'(1), lcb_pkg::DIM_W'(10), 1'b0);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b1);

        // Directed items on a three by two frame: black, white, each primary
        // at full scale, and a flag on pixels that do not close the frame.
        set_config(lcb_pkg::DIM_W'(3), lcb_pkg::DIM_W'(2), lcb_pkg::DIM_W'(10), 1'b0);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_pixel(16'hFFFF, 16'h0000, 16'h0000, 1'b0);
        send_pixel(16'h0000, 16'hFFFF, 16'h0000, 1'b1);
        send_pixel(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0);
        // A dark frame ends the sequence; its own extent is the default one.
        for (int i = 0; i < 6; i++) send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b1);

        // Threshold zero lights every pixel, and the frame ends lit.
        set_config(lcb_pkg::DIM_W'(2), lcb_pkg::DIM_W'(2), lcb_pkg::DIM_W'(0), 1'b0);
        for (int i = 0; i < 4; i++) send_pixel(16'h0000, 16'h0000, 16'h0000, i == 3);

        // A threshold above 100 lights nothing, not even white.
        set_config(lcb_pkg::DIM_W'(2), lcb_pkg::DIM_W'(1), lcb_pkg::DIM_W'(127), 1'b0);
        for (int i = 0; i < 2; i++) send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);

        // Greys on either side of the knee of the sRGB curve, a lit pixel at
        // column five, then the row is cut short by a narrower setting. The
        // right edge clamps to the last column of the narrower frame.
        set_config(lcb_pkg::DIM_W'(8), lcb_pkg::DIM_W'(1), lcb_pkg::DIM_W'(1), 1'b0);
        send_pixel(16'h0A50, 16'h0A50, 16'h0A50, 1'b0);
        send_pixel(16'h0A60, 16'h0A60, 16'h0A60, 1'b0);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        set_config(lcb_pkg::DIM_W'(3), lcb_pkg::DIM_W'(1), lcb_pkg::DIM_W'(1), 1'b0);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b1);

        // Random part in three stretches: the sender idles less than the
        // receiver, then the other way round, then neither idles.
        for (int seg = 0; seg < 3; seg++) begin
            seg_start = random_items;
            case (seg)
                0: begin
                    sender_idle_pct   = 20;
                    receiver_idle_pct = 48;
                    // A row wider than the limit, left open after a few pixels.
                    set_config(lcb_pkg::DIM_W'(2047), lcb_pkg::DIM_W'(1),
                               lcb_pkg::DIM_W'(5), 1'b1);
                    run_frames(1, 30, 1'b1, 1'b0, sent);
                end
                1: begin
                    sender_idle_pct   = 48;
                    receiver_idle_pct = 20;
                    // A frame at exactly the row limit, left open after a few rows.
                    set_config(lcb_pkg::DIM_W'(1), lcb_pkg::DIM_W'(1024),
                               lcb_pkg::DIM_W'(5), 1'b0);
                    run_frames(1, 30, 1'b1, 1'b0, sent);
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            while (random_items - seg_start < STRETCH_ITEMS) begin
                random_phase(sent);
                random_items += sent;
            end
        end

        drain_pipeline();
        sb.close_out();
        if (sb.failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: lit_region_crop_box_core.f
rtl/lcb_pkg.sv
rtl/lcb_luma.sv
rtl/lcb_frame_track.sv
rtl/lcb_box_merge.sv
rtl/lit_region_crop_box_core.sv
rtl/lcb_checker.sv
dv/lit_region_crop_box_core_tb.sv
